// ===== rtl/lvf_pkg.sv =====
// ----------------------------------------------------------------------------
// lvf_pkg
// Shared types and constants for the linear volume fade ramp.
// ----------------------------------------------------------------------------
`default_nettype none

package lvf_pkg;

	localparam int TIME_BITS_DEF      = 32;
	localparam int GAIN_FRAC_BITS_DEF = 15;

	// item operation codes; 5..7 are no-ops
	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_FADE_IN  = 3'd1,
		OP_FADE_OUT = 3'd2,
		OP_SET_VOL  = 3'd3,
		OP_STOP     = 3'd4
	} lvf_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} lvf_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} lvf_div_status_t;

endpackage

`default_nettype wire

// ===== rtl/lvf_ifs.sv =====
// ----------------------------------------------------------------------------
// lvf_ifs
// Valid/ready channels for fade commands and gain results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lvf_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [31:0] now_ms;
	logic [31:0] fade_length_ms;
	logic [15:0] volume_request;
	logic        player_active;

	modport source (output valid, operation, now_ms, fade_length_ms, volume_request,
		player_active, input ready);
	modport sink (input valid, operation, now_ms, fade_length_ms, volume_request,
		player_active, output ready);
endinterface

interface lvf_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] gain;
	logic        play_request;
	logic        stop_request;
	logic        fading_in;
	logic        fading_out;

	modport source (output valid, gain, play_request, stop_request, fading_in,
		fading_out, input ready);
	modport sink (input valid, gain, play_request, stop_request, fading_in,
		fading_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/lvf_div.sv =====
// ----------------------------------------------------------------------------
// lvf_div
// Radix-2 restoring fraction divider: quot = floor(num * 2^QW / den),
// one quotient bit per cycle. Requires num < den.
// ----------------------------------------------------------------------------
`default_nettype none

module lvf_div import lvf_pkg::*; #(
	parameter int W  = TIME_BITS_DEF,
	parameter int QW = GAIN_FRAC_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [W-1:0]  num,
	input  wire logic [W-1:0]  den,
	output lvf_div_status_t    status,
	output logic      [QW-1:0] quot
);

	localparam int CW = $clog2(QW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  den_q;
	logic [QW-1:0] quo_q;

	logic [W:0]    twice;
	logic [W:0]    diff;
	logic          ge;

	assign twice = {rem_q, 1'b0};
	assign diff  = twice - {1'b0, den_q};
	assign ge    = twice >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : twice[W-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quot        = quo_q;

endmodule

`default_nettype wire

// ===== rtl/linear_volume_fade_ramp_top.sv =====
// ----------------------------------------------------------------------------
// linear_volume_fade_ramp_top
// One mixer gain with linear fade-in / fade-out timed from item timestamps.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  cmd      in   valid/ready   operation, now_ms, fade_length_ms,
//                              volume_request, player_active
//  res      out  valid/ready   gain, play_request, stop_request,
//                              fading_in, fading_out
//
//  An update tick that lands inside a running fade goes through the
//  bit-serial divider (ST_DIV) before ST_EMIT; every other item, including
//  a tick that ends a fade, goes from ST_IDLE straight to ST_EMIT.
//  One item is in flight at a time; the next is taken once the result is
//  in the output register, which holds it until res.ready.
//  arst_n clears the gain and both fades.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_volume_fade_ramp_top import lvf_pkg::*; #(
	parameter int TIME_BITS      = TIME_BITS_DEF,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lvf_cmd_if.sink   cmd,
	lvf_res_if.source res
);

	localparam int TW = TIME_BITS;
	localparam int GW = GAIN_FRAC_BITS + 1;
	localparam logic [GW-1:0] UNITY = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

	lvf_state_t state_q, state_nxt;

	// fade state
	logic [GW-1:0] gain_q, gain_nxt;
	logic [TW-1:0] rise_len_q, rise_len_nxt;
	logic [TW-1:0] rise_start_q, rise_start_nxt;
	logic [TW-1:0] fall_len_q, fall_len_nxt;
	logic [TW-1:0] fall_start_q, fall_start_nxt;

	// latched item
	logic [2:0]    op_q;
	logic [TW-1:0] now_q;
	logic [TW-1:0] len_q;
	logic [15:0]   vol_q;
	logic          act_q;
	logic          lt_q;

	// output register
	logic          res_valid_q;
	logic [15:0]   res_gain_q;
	logic          res_play_q;
	logic          res_stop_q;
	logic          res_fin_q;
	logic          res_fout_q;

	logic          accept;
	logic          emit;
	logic          play_nxt;
	logic          stop_nxt;

	logic [63:0]   now_ext;
	logic [63:0]   len_ext;
	logic [TW-1:0] now_t;
	logic [TW-1:0] len_t;
	logic          rise_on;
	logic          fall_on;
	logic [TW-1:0] sel_start;
	logic [TW-1:0] sel_len;
	logic [TW-1:0] elapsed;
	logic          el_lt;
	logic          div_start;

	lvf_div_status_t        div_st;
	logic [GAIN_FRAC_BITS-1:0] quot;

	logic [31:0]   vol_ext;
	logic [31:0]   gain_ext;

	assign now_ext = 64'(cmd.now_ms);
	assign len_ext = 64'(cmd.fade_length_ms);
	assign now_t   = now_ext[TW-1:0];
	assign len_t   = len_ext[TW-1:0];

	// at most one fade runs; pick its timing
	assign rise_on   = rise_len_q != '0;
	assign fall_on   = fall_len_q != '0;
	assign sel_start = rise_on ? rise_start_q : fall_start_q;
	assign sel_len   = rise_on ? rise_len_q : fall_len_q;
	assign elapsed   = now_t - sel_start;
	assign el_lt     = elapsed < sel_len;

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = state_q == ST_IDLE;
	assign div_start = accept && (cmd.operation == OP_TICK) && (rise_on || fall_on) && el_lt;
	assign emit      = (state_q == ST_EMIT) && (!res_valid_q || res.ready);

	lvf_div #(
		.W  (TW),
		.QW (GAIN_FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (elapsed),
		.den    (sel_len),
		.status (div_st),
		.quot   (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = div_start ? ST_DIV : ST_EMIT;
				end
			end
			ST_DIV: begin
				if (div_st.done) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= cmd.operation;
			now_q <= now_t;
			len_q <= len_t;
			vol_q <= cmd.volume_request;
			act_q <= cmd.player_active;
			lt_q  <= el_lt;
		end
	end

	assign vol_ext = 32'(vol_q);

	// state update applied when the result is written
	always_comb begin
		gain_nxt       = gain_q;
		rise_len_nxt   = rise_len_q;
		rise_start_nxt = rise_start_q;
		fall_len_nxt   = fall_len_q;
		fall_start_nxt = fall_start_q;
		play_nxt       = 1'b0;
		stop_nxt       = 1'b0;
		case (op_q)
			OP_TICK: begin
				if (rise_on) begin
					if (lt_q) begin
						gain_nxt = {1'b0, quot};
					end else begin
						gain_nxt     = UNITY;
						rise_len_nxt = '0;
					end
				end else if (fall_on) begin
					if (lt_q) begin
						gain_nxt = UNITY - {1'b0, quot};
					end else begin
						gain_nxt     = '0;
						stop_nxt     = 1'b1;
						fall_len_nxt = '0;
					end
				end
			end
			OP_FADE_IN: begin
				rise_len_nxt   = len_q;
				rise_start_nxt = now_q;
				fall_len_nxt   = '0;
				gain_nxt       = '0;
				play_nxt       = 1'b1;
			end
			OP_FADE_OUT: begin
				if (act_q) begin
					fall_len_nxt   = len_q;
					fall_start_nxt = now_q;
					rise_len_nxt   = '0;
				end
			end
			OP_SET_VOL: begin
				gain_nxt = (vol_ext > 32'(UNITY)) ? UNITY : vol_ext[GW-1:0];
			end
			OP_STOP: begin
				gain_nxt = '0;
				stop_nxt = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q       <= '0;
			rise_len_q   <= '0;
			rise_start_q <= '0;
			fall_len_q   <= '0;
			fall_start_q <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (emit) begin
				gain_q       <= gain_nxt;
				rise_len_q   <= rise_len_nxt;
				rise_start_q <= rise_start_nxt;
				fall_len_q   <= fall_len_nxt;
				fall_start_q <= fall_start_nxt;
				res_valid_q  <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign gain_ext = 32'(gain_nxt);

	always_ff @(posedge clk) begin
		if (emit) begin
			res_gain_q <= gain_ext[15:0];
			res_play_q <= play_nxt;
			res_stop_q <= stop_nxt;
			res_fin_q  <= rise_len_nxt != '0;
			res_fout_q <= fall_len_nxt != '0;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.gain         = res_gain_q;
	assign res.play_request = res_play_q;
	assign res.stop_request = res_stop_q;
	assign res.fading_in    = res_fin_q;
	assign res.fading_out   = res_fout_q;

	// fade-in and fade-out cancel each other
	a_one_fade: assert property (@(posedge clk) disable iff (!arst_n)
		!(rise_on && fall_on))
		else $error("both fades active");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_st.busy)
		else $error("divider restarted while busy");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> state_q == ST_DIV)
		else $error("quotient arrived outside divide state");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		gain_q <= UNITY)
		else $error("gain above unity");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the linear volume fade ramp. Commands go in on the
// cmd channel with random gaps; each accepted command is run through an
// in-bench model of the gain and fade state. Every result on the res channel
// is compared with the oldest predicted result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import lvf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          N_ITEMS       = 1750;
	localparam int          MAX_REPORTS   = 10;
	localparam int          DRAIN_CYCLES  = 60;
	localparam int          HOLD_CYCLES   = 400;
	localparam logic [15:0] UNITY_GAIN    = 16'(1 << GAIN_FRAC_BITS_DEF);
	// operation codes the block ignores
	localparam logic [2:0]  OP_RSVD_FIRST = 3'd5;
	localparam logic [2:0]  OP_RSVD_LAST  = 3'd7;

	typedef struct {
		logic [2:0]  op;
		logic [31:0] now_ms;
		logic [31:0] fade_len;
		logic [15:0] vol;
		logic        active;
	} fade_cmd_t;

	typedef struct {
		logic [15:0] gain;
		logic        play;
		logic        stop;
		logic        fading_in;
		logic        fading_out;
	} gain_result_t;

	logic clk;
	logic arst_n;

	lvf_cmd_if cmd_ch ();
	lvf_res_if res_ch ();

	linear_volume_fade_ramp_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	fade_cmd_t    fade_cmds[$];
	gain_result_t gain_due[$];
	fade_cmd_t    next_cmd;
	int           n_total;
	int           n_taken;
	int           n_errors;
	logic         cmd_took;
	logic         hold_rx;

	// predicted block state
	logic [15:0] cur_gain;
	logic [31:0] rise_len;
	logic [31:0] rise_t0;
	logic [31:0] fall_len;
	logic [31:0] fall_t0;

	function automatic logic [15:0] ramp_frac(logic [31:0] el, logic [31:0] len);
		logic [63:0] num;
		num = {32'd0, el} << GAIN_FRAC_BITS_DEF;
		return 16'(num / {32'd0, len});
	endfunction

	function gain_result_t step_gain(fade_cmd_t c);
		gain_result_t r;
		logic [31:0]  el;
		r.play = 1'b0;
		r.stop = 1'b0;
		case (c.op)
			OP_TICK: begin
				if (rise_len != 0) begin
					el = c.now_ms - rise_t0;
					if (el < rise_len) begin
						cur_gain = ramp_frac(el, rise_len);
					end else begin
						cur_gain = UNITY_GAIN;
						rise_len = '0;
					end
				end
				if (fall_len != 0) begin
					el = c.now_ms - fall_t0;
					if (el < fall_len) begin
						cur_gain = UNITY_GAIN - ramp_frac(el, fall_len);
					end else begin
						cur_gain = '0;
						r.stop = 1'b1;
						fall_len = '0;
					end
				end
			end
			OP_FADE_IN: begin
				rise_len = c.fade_len;
				rise_t0 = c.now_ms;
				fall_len = '0;
				cur_gain = '0;
				r.play = 1'b1;
			end
			OP_FADE_OUT: begin
				if (c.active) begin
					fall_len = c.fade_len;
					fall_t0 = c.now_ms;
					rise_len = '0;
				end
			end
			OP_SET_VOL: begin
				cur_gain = (c.vol > UNITY_GAIN) ? UNITY_GAIN : c.vol;
			end
			OP_STOP: begin
				cur_gain = '0;
				r.stop = 1'b1;
			end
			default: ;
		endcase
		r.gain = cur_gain;
		r.fading_in = (rise_len != 0);
		r.fading_out = (fall_len != 0);
		return r;
	endfunction

	function automatic void add_item(logic [2:0] op, logic [31:0] now_ms,
		logic [31:0] fade_len, logic [15:0] vol, logic active);
		fade_cmd_t c;
		c.op = op;
		c.now_ms = now_ms;
		c.fade_len = fade_len;
		c.vol = vol;
		c.active = active;
		fade_cmds.push_back(c);
	endfunction

	function automatic logic [31:0] pick_len();
		int k;
		k = $urandom_range(99);
		if (k < 60)
			return $urandom_range(1, 300);
		else if (k < 75)
			return $urandom_range(1, 5);
		else if (k < 85)
			return '0;
		else if (k < 95)
			return $urandom;
		else
			return 32'hFFFF_FFFF;
	endfunction

	// phase 0: sender 23% idle, receiver 82%; phase 1 swapped; phase 2 none
	function automatic int tx_gap_pct();
		if (n_taken < n_total / 3)
			return 23;
		else if (n_taken < 2 * n_total / 3)
			return 82;
		else
			return 0;
	endfunction

	function automatic int rx_gap_pct();
		if (n_taken < n_total / 3)
			return 82;
		else if (n_taken < 2 * n_total / 3)
			return 23;
		else
			return 0;
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		hold_rx = 1'b0;
		cmd_took = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.operation = '0;
		cmd_ch.now_ms = '0;
		cmd_ch.fade_length_ms = '0;
		cmd_ch.volume_request = '0;
		cmd_ch.player_active = 1'b0;
		res_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// long receiver stall while the sender keeps offering
	initial begin
		while (n_taken < 200) @(posedge clk);
		hold_rx = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx = 1'b0;
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else if (!cmd_ch.valid || cmd_took) begin
			if (fade_cmds.size() != 0 && $urandom_range(99) >= tx_gap_pct()) begin
				next_cmd = fade_cmds.pop_front();
				cmd_ch.operation <= next_cmd.op;
				cmd_ch.now_ms <= next_cmd.now_ms;
				cmd_ch.fade_length_ms <= next_cmd.fade_len;
				cmd_ch.volume_request <= next_cmd.vol;
				cmd_ch.player_active <= next_cmd.active;
				cmd_ch.valid <= 1'b1;
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= !hold_rx && ($urandom_range(99) >= rx_gap_pct());
		end
	end

	always @(posedge clk) begin
		fade_cmd_t    c;
		gain_result_t e;
		cmd_took = arst_n && cmd_ch.valid && cmd_ch.ready;
		if (cmd_took) begin
			c.op = cmd_ch.operation;
			c.now_ms = cmd_ch.now_ms;
			c.fade_len = cmd_ch.fade_length_ms;
			c.vol = cmd_ch.volume_request;
			c.active = cmd_ch.player_active;
			gain_due.push_back(step_gain(c));
			n_taken++;
		end
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (gain_due.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS)
					$display("%0t: result with nothing expected: gain=%0d", $realtime,
						res_ch.gain);
			end else begin
				e = gain_due.pop_front();
				if (res_ch.gain !== e.gain || res_ch.play_request !== e.play
					|| res_ch.stop_request !== e.stop || res_ch.fading_in !== e.fading_in
					|| res_ch.fading_out !== e.fading_out) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS) begin
						$write("%0t: exp gain=%0d play=%b stop=%b in=%b out=%b, ", $realtime,
							e.gain, e.play, e.stop, e.fading_in, e.fading_out);
						$display("got gain=%0d play=%b stop=%b in=%b out=%b",
							res_ch.gain, res_ch.play_request, res_ch.stop_request,
							res_ch.fading_in, res_ch.fading_out);
					end
				end
			end
		end
	end

	initial begin
		logic [31:0] t;
		logic [31:0] len;
		int          kind;
		int          n_ticks;

		cur_gain = '0;
		rise_len = '0;
		rise_t0 = '0;
		fall_len = '0;
		fall_t0 = '0;
		n_taken = 0;
		n_errors = 0;

		// directed part
		add_item(OP_TICK, 32'd0, 32'd0, 16'd0, 1'b0);
		add_item(OP_FADE_IN, 32'd5, 32'd0, 16'hFFFF, 1'b1);     // zero-length fade-in
		add_item(OP_TICK, 32'd6, 32'hFFFF_FFFF, 16'd0, 1'b0);
		add_item(OP_FADE_IN, 32'd1000, 32'd100, 16'd0, 1'b0);
		add_item(OP_TICK, 32'd1000, 32'd0, 16'd0, 1'b0);
		add_item(OP_TICK, 32'd1050, 32'd0, 16'd0, 1'b0);
		add_item(OP_TICK, 32'd1099, 32'd0, 16'd0, 1'b0);
		add_item(OP_TICK, 32'd1100, 32'd0, 16'd0, 1'b0);
		add_item(OP_FADE_OUT, 32'd1500, 32'd50, 16'd0, 1'b0);   // player idle: no effect
		add_item(OP_FADE_OUT, 32'd2000, 32'd50, 16'd0, 1'b1);
		add_item(OP_TICK, 32'd2025, 32'd0, 16'd0, 1'b0);
		add_item(OP_STOP, 32'd2030, 32'd0, 16'd0, 1'b0);        // fade keeps running
		add_item(OP_TICK, 32'd2049, 32'd0, 16'd0, 1'b0);
		add_item(OP_TICK, 32'd2050, 32'd0, 16'd0, 1'b0);
		add_item(OP_SET_VOL, 32'd2100, 32'd0, 16'hFFFF, 1'b0);
		add_item(OP_SET_VOL, 32'd2101, 32'd0, UNITY_GAIN + 16'd1, 1'b0);
		add_item(OP_SET_VOL, 32'd2102, 32'd0, UNITY_GAIN - 16'd1, 1'b0);
		add_item(OP_SET_VOL, 32'd2103, 32'd0, 16'd0, 1'b0);
		add_item(OP_FADE_IN, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 16'd0, 1'b0);
		add_item(OP_TICK, 32'h0000_000F, 32'd0, 16'd0, 1'b0);   // elapsed wraps
		add_item(OP_TICK, 32'hFFFF_FFEF, 32'd0, 16'd0, 1'b0);
		add_item(OP_FADE_OUT, 32'd300, 32'd1000, 16'd0, 1'b1);
		add_item(OP_FADE_IN, 32'd400, 32'd10, 16'd0, 1'b1);     // cancels the fade-out
		add_item(OP_FADE_OUT, 32'd401, 32'd0, 16'd0, 1'b1);     // zero length, cancels
		add_item(OP_TICK, 32'd405, 32'd0, 16'd0, 1'b1);
		for (logic [2:0] op = OP_RSVD_FIRST; op <= OP_RSVD_LAST && op >= OP_RSVD_FIRST;
			op++)
			add_item(op, $urandom, $urandom, 16'($urandom), 1'b1);

		// random part: mostly fade sequences with ticks, the rest noise
		t = $urandom;
		while (fade_cmds.size() < N_ITEMS) begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				len = pick_len();
				if (kind < 40)
					add_item(OP_FADE_IN, t, len, 16'($urandom), 1'($urandom));
				else
					add_item(OP_FADE_OUT, t, len, 16'($urandom),
						1'($urandom_range(9) != 0));
				n_ticks = $urandom_range(1, 8);
				repeat (n_ticks) begin
					if (len != 0 && len <= 300)
						t += $urandom_range(0, len / 3 + 1);
					else if ($urandom_range(9) == 0)
						t += $urandom;
					else
						t += $urandom_range(0, 1000);
					case ($urandom_range(19))
						0: add_item(OP_STOP, t, $urandom, 16'($urandom), 1'($urandom));
						1: add_item(OP_SET_VOL, t, $urandom, 16'($urandom), 1'($urandom));
						default: add_item(OP_TICK, t, $urandom, 16'($urandom), 1'($urandom));
					endcase
				end
			end else if (kind < 80) begin
				add_item(OP_SET_VOL, t, $urandom,
					($urandom_range(1) != 0) ? 16'($urandom_range(0, 32768)) : 16'($urandom),
					1'($urandom));
			end else if (kind < 85) begin
				add_item(OP_STOP, t, $urandom, 16'($urandom), 1'($urandom));
			end else if (kind < 90) begin
				add_item(3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST)), t, $urandom,
					16'($urandom), 1'($urandom));
			end else begin
				add_item(3'($urandom_range(0, 7)), $urandom, $urandom, 16'($urandom),
					1'($urandom));
			end
			t += $urandom_range(0, 50);
			if ($urandom_range(49) == 0)
				t = $urandom;
		end
		n_total = fade_cmds.size();

		while (n_taken < n_total) @(posedge clk);
		while (gain_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== linear_volume_fade_ramp_top.f =====
rtl/lvf_pkg.sv
rtl/lvf_ifs.sv
rtl/lvf_div.sv
rtl/linear_volume_fade_ramp_top.sv
verif/tb_top.sv
